// File: hdl/dpm_pkg.sv
// ----------------------------------------------------------------------------
// dpm_pkg
// shared types and constants for the dense prim spanning tree block
// ----------------------------------------------------------------------------
package dpm_pkg;

    localparam int VERTEX_W   = 6;
    localparam int WEIGHT_W   = 8;
    localparam int CFG_W      = 7;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_RUN   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_RELAX,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

endpackage

// File: hdl/dense_prim_mst.sv
// ----------------------------------------------------------------------------
// dense_prim_mst
// prim minimum spanning tree over a dense weight matrix held in memory
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | request: tuser opcode, tdata row/column/weight
//  m_*      | out       | tree edge per vertex 1..n-1, tuser reachable, tlast
//  cfg_*    | in        | vertex_count register write
//
//  a matrix write is taken while idle; a run clears all n vertex entries,
//  then sweeps all n entries once per picked vertex (at most n-1), then
//  reads then presents each result, as each memory has a single read port
//  m_tready low holds the current result; no request is taken during a run
//  reset leaves the matrix undefined and vertex_count at 64
// ----------------------------------------------------------------------------
module dense_prim_mst #(
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dpm_pkg::S_TDATA_W-1:0] s_tdata,   // row, column, weight
    input  logic                          s_tuser,   // opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dpm_pkg::M_TDATA_W-1:0] m_tdata,   // vertex, parent, edge_weight
    output logic                          m_tuser,   // reachable
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dpm_pkg::CFG_W-1:0]     cfg_data
);

    import dpm_pkg::*;

    localparam int VW = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int SW = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
    localparam int KW = SW + 1;
    localparam int RW = 1 + VW + KW;
    localparam int WA = 2 * VW;
    localparam logic [KW-1:0]    KEY_INF = {1'b1, {SW{1'b0}}};
    localparam logic [CFG_W-1:0] MAX_CFG = CFG_W'(MAX_VERTICES);
    localparam logic [CFG_W-1:0] MIN_CFG = CFG_W'(2);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] count_reg;
    logic [CW-1:0]    n_reg;
    logic [CW-1:0]    idx_reg;
    logic             rd_vld_reg;
    logic [VW-1:0]    rd_idx_reg;
    logic [CW-1:0]    step_reg;
    logic [VW-1:0]    pick_reg;
    logic [KW-1:0]    min_key_reg;
    logic [VW-1:0]    min_idx_reg;
    logic [VW-1:0]    em_idx_reg;

    logic [VERTEX_W-1:0] in_row, in_col;
    logic [WEIGHT_W-1:0] in_weight;
    logic [CW-1:0]       n_sat;
    logic                run_req, wr_req, in_range;

    logic          wram_we, wram_re;
    logic [WA-1:0] wram_waddr, wram_raddr;
    logic [SW-1:0] wram_wdata, wram_rdata;

    logic          vram_we, vram_re;
    logic [VW-1:0] vram_waddr, vram_raddr;
    logic [RW-1:0] vram_wdata, vram_rdata;

    logic          old_in;
    logic [VW-1:0] old_par;
    logic [KW-1:0] old_key;
    logic          is_pick, upd, new_in, cand;
    logic [KW-1:0] new_key, fin_key;
    logic [VW-1:0] new_par, fin_idx;
    logic          issue, round_end, more, clear_end, last_out, reach;

    assign in_row    = s_tdata[VERTEX_W-1:0];
    assign in_col    = s_tdata[2*VERTEX_W-1:VERTEX_W];
    assign in_weight = s_tdata[2*VERTEX_W+WEIGHT_W-1:2*VERTEX_W];

    assign run_req  = s_tvalid && s_tready && (s_tuser == OP_RUN);
    assign wr_req   = s_tvalid && s_tready && (s_tuser == OP_WRITE);
    assign in_range = ({1'b0, in_row} < MAX_CFG) && ({1'b0, in_col} < MAX_CFG);

    always_comb
    begin
        if (count_reg < MIN_CFG)
        begin
            n_sat = CW'(2);
        end
        else if (count_reg > MAX_CFG)
        begin
            n_sat = CW'(MAX_VERTICES);
        end
        else
        begin
            n_sat = count_reg[CW-1:0];
        end
    end

    assign cfg_ready = 1'b1;

    // vertex entry: in tree, parent, key
    assign old_in  = vram_rdata[RW-1];
    assign old_par = vram_rdata[KW+VW-1:KW];
    assign old_key = vram_rdata[KW-1:0];

    assign is_pick = (rd_idx_reg == pick_reg);
    assign upd     = (wram_rdata != '0) && !old_in && !is_pick
                     && ({1'b0, wram_rdata} < old_key);
    assign new_key = upd ? {1'b0, wram_rdata} : old_key;
    assign new_par = upd ? pick_reg : old_par;
    assign new_in  = old_in | is_pick;

    // running minimum over the vertices outside the tree, lowest index wins
    assign cand    = !new_in && (new_key < min_key_reg);
    assign fin_key = cand ? new_key : min_key_reg;
    assign fin_idx = cand ? rd_idx_reg : min_idx_reg;

    assign issue     = (state_reg == S_RELAX) && (idx_reg < n_reg);
    assign round_end = (state_reg == S_RELAX) && rd_vld_reg
                       && (CW'(rd_idx_reg) == n_reg - CW'(1));
    assign more      = (({1'b0, step_reg} + (CW+1)'(2)) < {1'b0, n_reg})
                       && (fin_key != KEY_INF);
    assign clear_end = (idx_reg == n_reg - CW'(1));
    assign last_out  = (CW'(em_idx_reg) == n_reg - CW'(1));
    assign reach     = !old_key[SW];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (run_req)
                begin
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                if (clear_end)
                begin
                    state_next = S_RELAX;
                end
            end
            S_RELAX:
            begin
                if (round_end && !more)
                begin
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (m_tready)
                begin
                    state_next = last_out ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        s_tready   = (state_reg == S_IDLE);
        m_tvalid   = (state_reg == S_EMIT_OUT);

        wram_we    = wr_req && in_range;
        wram_waddr = {in_row[VW-1:0], in_col[VW-1:0]};
        wram_wdata = in_weight[SW-1:0];
        wram_re    = issue;
        wram_raddr = {pick_reg, idx_reg[VW-1:0]};

        vram_we    = 1'b0;
        vram_waddr = rd_idx_reg;
        vram_wdata = {new_in, new_par, new_key};
        vram_re    = issue;
        vram_raddr = idx_reg[VW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                vram_we    = 1'b1;
                vram_waddr = idx_reg[VW-1:0];
                vram_wdata = {1'b0, {VW{1'b0}},
                              (idx_reg == '0) ? {KW{1'b0}} : KEY_INF};
            end
            S_RELAX:
            begin
                vram_we = rd_vld_reg;
            end
            S_EMIT_RD:
            begin
                vram_re    = 1'b1;
                vram_raddr = em_idx_reg;
            end
            default:
            begin
                vram_we = 1'b0;
            end
        endcase
    end

    assign m_tdata = {(M_TDATA_W - 2*VERTEX_W - WEIGHT_W)'(0),
                      reach ? WEIGHT_W'(old_key[SW-1:0]) : WEIGHT_W'(0),
                      reach ? VERTEX_W'(old_par) : VERTEX_W'(0),
                      VERTEX_W'(em_idx_reg)};
    assign m_tuser = reach;
    assign m_tlast = last_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= CFG_RESET;
            n_reg       <= CW'(2);
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            rd_idx_reg  <= '0;
            step_reg    <= '0;
            pick_reg    <= '0;
            min_key_reg <= KEY_INF;
            min_idx_reg <= '0;
            em_idx_reg  <= VW'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (run_req)
                    begin
                        n_reg   <= n_sat;
                        idx_reg <= '0;
                    end
                end
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + CW'(1);
                    if (clear_end)
                    begin
                        idx_reg     <= '0;
                        step_reg    <= '0;
                        pick_reg    <= '0;
                        min_key_reg <= KEY_INF;
                        rd_vld_reg  <= 1'b0;
                    end
                end
                S_RELAX:
                begin
                    rd_vld_reg <= issue;
                    rd_idx_reg <= idx_reg[VW-1:0];
                    if (issue)
                    begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                    if (rd_vld_reg)
                    begin
                        min_key_reg <= fin_key;
                        min_idx_reg <= fin_idx;
                    end
                    if (round_end)
                    begin
                        min_key_reg <= KEY_INF;
                        idx_reg     <= '0;
                        step_reg    <= step_reg + CW'(1);
                        pick_reg    <= fin_idx;
                        rd_vld_reg  <= 1'b0;
                        em_idx_reg  <= VW'(1);
                    end
                end
                S_EMIT_OUT:
                begin
                    if (m_tready && !last_out)
                    begin
                        em_idx_reg <= em_idx_reg + VW'(1);
                    end
                end
                default:
                begin
                    rd_vld_reg <= 1'b0;
                end
            endcase
        end
    end

    dpm_ram #(
        .AW (WA),
        .DW (SW)
    ) u_weight_ram (
        .clk   (clk),
        .we    (wram_we),
        .waddr (wram_waddr),
        .wdata (wram_wdata),
        .re    (wram_re),
        .raddr (wram_raddr),
        .rdata (wram_rdata)
    );

    dpm_ram #(
        .AW (VW),
        .DW (RW)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .re    (vram_re),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("request taken while a result is pending");

    a_rmw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (vram_we && vram_re) |-> (vram_waddr != vram_raddr))
        else $error("vertex entry read and written in the same cycle");

    a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RELAX) |-> (CW'(pick_reg) < n_reg))
        else $error("picked vertex outside the active range");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block not idle after the final edge");
`endif

endmodule

// File: hdl/dpm_ram.sv
// ----------------------------------------------------------------------------
// dpm_ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module dpm_ram #(
    parameter int AW = 6,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
